FILE: design/inner_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Inner frame deframer assertion macros
// Wrappers around concurrent assertions, clocked on i_clk and disabled
// while i_rst_n is low. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef INNER_FRAME_DEFRAMER_MACROS_SVH
`define INNER_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define IFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication.
`define IFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define IFD_ASSERT_SAME(label, ante, cons)
`define IFD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/ifd_pkg.sv
// ----------------------------------------------------------------------------
// Inner frame deframer package
// Types and constants shared by the deframer and its stream interfaces.
// ----------------------------------------------------------------------------
package ifd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int MAJOR_W   = 4;
    localparam int MINOR_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int OUT_DEPTH = 4;

    // A frame needs a command byte, two length bytes and a checksum.
    localparam int MIN_FRAME_BYTES = 4;
    localparam int SEEN_W          = 3;

    localparam logic [BYTE_W-1:0] SUM_CMD_MASK = 8'hFE;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_BYPASS = 1'b1;

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_ZERO_LEN  = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        PH_CMD    = 6'b000001,
        PH_LEN_LO = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_CHECK  = 6'b010000,
        PH_TAIL   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic                item_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [MAJOR_W-1:0]  command_major;
        logic [MINOR_W-1:0]  command_minor;
        logic                no_ack_flag;
        logic [LEN_W-1:0]    frame_length_field;
        logic [BYTE_W-1:0]   received_check;
        logic                check_good;
        t_status             frame_status;
        logic                run_last;
    } t_result;

endpackage

FILE: design/ifd_in_if.sv
// ----------------------------------------------------------------------------
// Deframer input stream
// One frame byte per beat, with a mark on the frame's final byte.
// ----------------------------------------------------------------------------
interface ifd_in_if;

    logic                        valid;
    logic                        ready;
    logic [ifd_pkg::BYTE_W-1:0]  frame_byte;
    logic                        frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);

endinterface

FILE: design/ifd_out_if.sv
// ----------------------------------------------------------------------------
// Deframer result stream
// One payload byte or one frame status summary per beat.
// ----------------------------------------------------------------------------
interface ifd_out_if;

    logic                          valid;
    logic                          ready;
    logic                          item_kind;
    logic [ifd_pkg::BYTE_W-1:0]    payload_byte;
    logic [ifd_pkg::MAJOR_W-1:0]   command_major;
    logic [ifd_pkg::MINOR_W-1:0]   command_minor;
    logic                          no_ack_flag;
    logic [ifd_pkg::LEN_W-1:0]     frame_length_field;
    logic [ifd_pkg::BYTE_W-1:0]    received_check;
    logic                          check_good;
    logic [ifd_pkg::STATUS_W-1:0]  frame_status;
    logic                          run_last;

    modport source (
        output valid, output item_kind, output payload_byte, output command_major,
        output command_minor, output no_ack_flag, output frame_length_field,
        output received_check, output check_good, output frame_status,
        output run_last, input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input command_major,
        input command_minor, input no_ack_flag, input frame_length_field,
        input received_check, input check_good, input frame_status,
        input run_last, output ready
    );

endinterface

FILE: design/inner_frame_deframer.sv
// ----------------------------------------------------------------------------
// Inner frame deframer
// Splits an inner frame into payload beats and one status beat per frame.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on i_in, one per beat, with frame_end set on the last
// byte. A frame is a command byte, a little-endian 16-bit length L, L-1 data
// bytes and a checksum byte; anything after the checksum is dropped until
// frame_end. Each data byte leaves on o_out as a payload beat, and frame_end
// produces one status beat (command fields, length, checksum, check result
// and an error code). A final data byte carrying frame_end yields its payload
// beat and then the status beat.
// Each input byte's result beats are registered in the output queue. The
// parser takes one byte per cycle while i_in.ready is high; results go
// through a small output queue that drains one beat per cycle, so a
// sustained rate of one byte per cycle holds while the receiver keeps up.
// i_in.ready stays high as long as the queue has room for the two beats
// one byte can cause. When the receiver stalls, results collect in the queue
// and i_in.ready drops once fewer than two slots are free; nothing is lost.
// A synchronous reset (i_rst_n low) empties the queue, returns the parser to
// the command byte and clears both configuration registers to zero. The
// checksum target and bypass registers are written through the i_cfg_* port;
// the user must write them only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`include "inner_frame_deframer_macros.svh"

module inner_frame_deframer #(
    parameter int FIFO_DEPTH = ifd_pkg::OUT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ifd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ifd_pkg::BYTE_W-1:0]    i_cfg_data,
    ifd_in_if.sink                        i_in,
    ifd_out_if.source                     o_out
);

    import ifd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration.
    logic [BYTE_W-1:0] r_cfg_target;
    logic [BYTE_W-1:0] r_cfg_bypass;

    // Parser state.
    t_phase             r_phase,     n_phase;
    logic [SEEN_W-1:0]  r_seen,      n_seen;
    logic [BYTE_W-1:0]  r_command,   n_command;
    logic [LEN_W-1:0]   r_length,    n_length;
    logic [BYTE_W-1:0]  r_sum,       n_sum;
    logic [BYTE_W-1:0]  r_check,     n_check;
    logic [LEN_W-1:0]   r_data_left, n_data_left;

    // Result queue.
    t_result            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic               in_fire;
    logic               out_fire;
    logic               data_hit;
    logic [1:0]         push_cnt;
    t_result            data_res;
    t_result            stat_res;
    t_result            first_res;
    t_status            stat_code;
    logic [BYTE_W-1:0]  expected;
    t_result            head;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    // Room for two beats: a final data byte produces a payload and a status.
    assign i_in.ready = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_target <= '0;
            r_cfg_bypass <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CHECKSUM_TARGET: r_cfg_target <= i_cfg_data;
                CFG_CHECKSUM_BYPASS: r_cfg_bypass <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parser: one phase step per byte.
    always_comb begin
        n_phase     = r_phase;
        n_command   = r_command;
        n_length    = r_length;
        n_sum       = r_sum;
        n_check     = r_check;
        n_data_left = r_data_left;
        data_hit    = 1'b0;
        n_seen      = (r_seen == SEEN_W'(MIN_FRAME_BYTES)) ? r_seen : r_seen + 1'b1;

        unique case (r_phase)
            PH_CMD: begin
                n_command = i_in.frame_byte;
                n_sum     = i_in.frame_byte & SUM_CMD_MASK;
                n_phase   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {{(LEN_W-BYTE_W){1'b0}}, i_in.frame_byte};
                n_sum    = r_sum + i_in.frame_byte;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = {i_in.frame_byte, r_length[BYTE_W-1:0]};
                n_sum    = r_sum + i_in.frame_byte;
                if (n_length == '0) begin
                    n_phase = PH_TAIL;
                end else if (n_length == LEN_W'(1)) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_data_left = n_length - 1'b1;
                    n_phase     = PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum       = r_sum + i_in.frame_byte;
                data_hit    = 1'b1;
                n_data_left = r_data_left - 1'b1;
                if (n_data_left == '0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_check = i_in.frame_byte;
                n_phase = PH_TAIL;
            end
            default: begin
                n_phase = PH_TAIL;
            end
        endcase
    end

    // Status of the frame as it stands after this byte.
    assign expected = r_cfg_target - n_sum;

    always_comb begin
        if (n_seen < SEEN_W'(MIN_FRAME_BYTES)) begin
            stat_code = ST_SHORT;
        end else if (n_length == '0) begin
            stat_code = ST_ZERO_LEN;
        end else if (n_phase != PH_TAIL) begin
            stat_code = ST_TRUNCATED;
        end else begin
            stat_code = ST_OK;
        end
    end

    always_comb begin
        data_res              = '0;
        data_res.item_kind    = KIND_DATA;
        data_res.payload_byte = i_in.frame_byte;
        data_res.run_last     = !i_in.frame_end;

        stat_res              = '0;
        stat_res.item_kind    = KIND_STATUS;
        stat_res.frame_status = stat_code;
        stat_res.run_last     = 1'b1;
        if (stat_code == ST_OK) begin
            stat_res.command_major      = n_command[BYTE_W-1 -: MAJOR_W];
            stat_res.command_minor      = n_command[MINOR_W:1];
            stat_res.no_ack_flag        = n_command[0];
            stat_res.frame_length_field = n_length;
            stat_res.received_check     = n_check;
            stat_res.check_good         = (n_check == r_cfg_bypass) || (n_check == expected);
        end

        first_res = data_hit ? data_res : stat_res;
        push_cnt  = 2'(data_hit) + 2'(i_in.frame_end);
        if (!in_fire) begin
            push_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CMD;
            r_seen      <= '0;
            r_command   <= '0;
            r_length    <= '0;
            r_sum       <= '0;
            r_check     <= '0;
            r_data_left <= '0;
        end else if (in_fire) begin
            if (i_in.frame_end) begin
                // The frame is done: start over on the next command byte.
                r_phase     <= PH_CMD;
                r_seen      <= '0;
                r_command   <= '0;
                r_length    <= '0;
                r_sum       <= '0;
                r_check     <= '0;
                r_data_left <= '0;
            end else begin
                r_phase     <= n_phase;
                r_seen      <= n_seen;
                r_command   <= n_command;
                r_length    <= n_length;
                r_sum       <= n_sum;
                r_check     <= n_check;
                r_data_left <= n_data_left;
            end
        end
    end

    // Result queue: up to two writes and one read per cycle.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_res;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + 1'b1] <= stat_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(out_fire);
            r_count  <= r_count + CNT_W'(push_cnt) - CNT_W'(out_fire);
        end
    end

    assign head = r_fifo[r_rd_ptr];

    assign o_out.valid              = (r_count != '0);
    assign o_out.item_kind          = head.item_kind;
    assign o_out.payload_byte       = head.payload_byte;
    assign o_out.command_major      = head.command_major;
    assign o_out.command_minor      = head.command_minor;
    assign o_out.no_ack_flag        = head.no_ack_flag;
    assign o_out.frame_length_field = head.frame_length_field;
    assign o_out.received_check     = head.received_check;
    assign o_out.check_good         = head.check_good;
    assign o_out.frame_status       = head.frame_status;
    assign o_out.run_last           = head.run_last;

    // Checks.
    `IFD_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(FIFO_DEPTH))
    `IFD_ASSERT_NEXT(a_restart_after_end, in_fire && i_in.frame_end, r_phase == PH_CMD)
    `IFD_ASSERT_SAME(a_data_left_live, r_phase == PH_DATA, r_data_left != '0)
    `IFD_ASSERT_SAME(a_error_fields_zero,
        o_out.valid && o_out.item_kind == KIND_STATUS && o_out.frame_status != ST_OK,
        o_out.frame_length_field == '0 && o_out.received_check == '0 && !o_out.check_good)

endmodule
